// ----- rtl/core/tapr_pkg.sv -----
`timescale 1ns / 1ps

package tapr_pkg;

   // Register map
   localparam int THR_BITS       = 15;
   localparam int RATE_BITS      = 18;
   localparam int CSR_IDX_BITS   = 1;
   localparam int CSR_DATA_BITS  = 18;

   localparam logic [CSR_IDX_BITS-1:0] REG_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_RATE_HZ   = 1'd1;

   localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = 15'd2048;
   localparam logic [RATE_BITS-1:0] RATE_HZ_RESET   = 18'd44100;

   // Tape tick clock, 3.5 MHz
   localparam int TICK_BITS = 22;
   localparam logic [TICK_BITS-1:0] TICK_HZ = 22'd3500000;

   // Result fields
   localparam int KIND_BITS = 2;
   localparam int DUR_BITS  = 41;

   localparam logic [KIND_BITS-1:0] KIND_SILENCE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_POS     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_NEG     = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // take the sample on the input channel
      logic mul_step;   // one shift-add step of count * tick rate
      logic div_step;   // one restoring division step
      logic step_clr;   // restart the step counter
      logic out_load;   // move the finished pulse into the output register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic emit;       // current input sample ends a pulse
      logic mul_last;   // last multiply step in progress
      logic div_last;   // last divide step in progress
      logic out_free;   // output register can take a new pulse
   } dp_status_type;

endpackage

// ----- rtl/core/tapr_ctrl.sv -----
`timescale 1ns / 1ps

module tapr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  tapr_pkg::dp_status_type status,
   output tapr_pkg::dp_cmd_type    cmd
);
   import tapr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && status.emit) begin
               cmd.step_clr = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               cmd.step_clr = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to drain
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/tapr_dp.sv -----
`timescale 1ns / 1ps

module tapr_dp #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [tapr_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [tapr_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]         sample,
   input  tapr_pkg::dp_cmd_type                  cmd,
   output tapr_pkg::dp_status_type               status,
   input  logic                                  rsp_tready,
   output logic                                  rsp_valid,
   output logic [tapr_pkg::KIND_BITS-1:0]        rsp_kind,
   output logic [tapr_pkg::DUR_BITS-1:0]         rsp_duration
);
   import tapr_pkg::*;

   localparam int PROD_W    = COUNT_BITS + TICK_BITS;
   localparam int STEP_BITS = $clog2(PROD_W);
   localparam int CMP_W     = (SAMPLE_BITS > THR_BITS + 1) ? SAMPLE_BITS : THR_BITS + 1;
   localparam int WIDE_W    = (PROD_W > DUR_BITS + 1) ? PROD_W : DUR_BITS + 1;

   typedef enum logic [4:0] {
      P_START = 5'b00001,
      P_PRISE = 5'b00010,
      P_PFALL = 5'b00100,
      P_NFALL = 5'b01000,
      P_NRISE = 5'b10000
   } phase_type;

   // configuration
   logic [THR_BITS-1:0]  threshold_ff;
   logic [RATE_BITS-1:0] rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rate_ff      <= RATE_HZ_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_wdata[THR_BITS-1:0];
            REG_RATE_HZ:   rate_ff      <= csr_wdata[RATE_BITS-1:0];
            default:       ;
         endcase
      end
   end

   // half-wave tracker
   phase_type              phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  count_ff, count_inc;
   logic signed [CMP_W-1:0] s_w, hi_w, lo_w;
   logic                   emit;
   logic [KIND_BITS-1:0]   kind;

   assign s_w       = CMP_W'(sample);
   assign hi_w      = signed'(CMP_W'(threshold_ff));
   assign lo_w      = -hi_w;
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      emit     = 1'b0;
      kind     = KIND_SILENCE;
      case (phase_ff)
         P_PRISE: begin
            if (s_w > hi_w) phase_in = P_PFALL;
         end
         P_PFALL: begin
            if (s_w < 0) begin
               phase_in = (s_w < lo_w) ? P_NRISE : P_NFALL;
               emit     = 1'b1;
               kind     = KIND_POS;
            end
         end
         P_NFALL: begin
            if (s_w < lo_w) phase_in = P_NRISE;
         end
         P_NRISE: begin
            if (s_w > 0) begin
               phase_in = (s_w > hi_w) ? P_PFALL : P_PRISE;
               emit     = 1'b1;
               kind     = KIND_NEG;
            end
         end
         default: begin
            // start phase: wait for the first peak, leading silence if late
            if (s_w > hi_w || s_w < lo_w) begin
               phase_in = (s_w > hi_w) ? P_PFALL : P_NRISE;
               emit     = (count_inc > COUNT_BITS'(2));
            end
         end
      endcase
   end

   // duration unit: serial multiply by the tick rate, then restoring divide
   logic [COUNT_BITS-1:0] mcand_ff;
   logic [TICK_BITS-1:0]  tick_sr_ff;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [RATE_BITS-1:0]  rem_ff, rem_in;
   logic [RATE_BITS:0]    rem_sh;
   logic                  q_bit;
   logic [STEP_BITS-1:0]  step_ff;
   logic [KIND_BITS-1:0]  kind_ff;

   assign rem_sh = {rem_ff, acc_ff[PROD_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, rate_ff});

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      if (cmd.mul_step) begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                + (tick_sr_ff[TICK_BITS-1] ? PROD_W'(mcand_ff) : '0);
      end else if (cmd.div_step) begin
         acc_in = {acc_ff[PROD_W-2:0], q_bit};
         rem_in = q_bit ? RATE_BITS'(rem_sh - {1'b0, rate_ff}) : rem_sh[RATE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_START;
         count_ff <= '0;
      end else if (cmd.accept) begin
         phase_ff <= phase_in;
         count_ff <= emit ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_clr) begin
         step_ff <= '0;
      end else if (cmd.mul_step || cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.accept && emit) begin
         mcand_ff   <= count_inc;
         kind_ff    <= kind;
         tick_sr_ff <= TICK_HZ;
         acc_ff     <= '0;
         rem_ff     <= '0;
      end else begin
         if (cmd.mul_step) tick_sr_ff <= {tick_sr_ff[TICK_BITS-2:0], 1'b0};
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   // output register
   logic [WIDE_W-1:0]   quo_w;
   logic [DUR_BITS-1:0] dur_sat;
   logic                rsp_valid_ff;
   logic [KIND_BITS-1:0] rsp_kind_ff;
   logic [DUR_BITS-1:0] rsp_dur_ff;

   assign quo_w   = WIDE_W'(acc_ff);
   assign dur_sat = (rate_ff == '0 || (|quo_w[WIDE_W-1:DUR_BITS])) ? '1
                  : quo_w[DUR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_kind_ff <= kind_ff;
         rsp_dur_ff  <= dur_sat;
      end
   end

   assign status.emit     = emit;
   assign status.mul_last = (step_ff == STEP_BITS'(TICK_BITS - 1));
   assign status.div_last = (step_ff == STEP_BITS'(PROD_W - 1));
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_duration = rsp_dur_ff;

endmodule

// ----- rtl/core/tape_audio_pulse_recovery.sv -----
`timescale 1ns / 1ps

// Tape audio pulse recovery: half-wave detector with hysteresis.
// Input channel req_*: one signed audio sample per item. Result channel
// rsp_*: at most one pulse item per sample, kind in tuser, duration in
// 3.5 MHz ticks in tdata. Config port csr_*: index 0 threshold, index 1
// sample rate in Hz; the user must see that it is written only while the
// block is idle, as the block does not enforce it. A sample that ends no
// pulse is taken with req_tready high. A sample that ends a pulse is taken,
// then req_tready stays low for TICK_BITS (22) shift-add multiply steps,
// COUNT_BITS + 22 restoring divide steps and the load into the output
// register, and the next sample is taken only after that load. The serial
// multiply and divide over the count * 3500000 product hold the input. The
// pulse then sits in the output register while new samples are taken.
// If the output register is still full when the next pulse finishes, the
// block holds in its done state with req_tready low until rsp_tready.
// Reset (synchronous, active high) puts the tracker in its start phase,
// clears the sample count, empties the output register and restores the
// threshold to 2048 and rate to 44100.

module tape_audio_pulse_recovery #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample in
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,  // [SAMPLE_BITS-1:0] sample
   // pulse out
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [47:0]                            rsp_tdata,  // [40:0] duration
   output logic [tapr_pkg::KIND_BITS-1:0]         rsp_tuser,  // [1:0] pulse_kind
   // config
   input  logic                                   csr_we,
   input  logic [tapr_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [tapr_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import tapr_pkg::*;

   dp_cmd_type             cmd;
   dp_status_type          status;
   logic [DUR_BITS-1:0]    duration;
   logic signed [SAMPLE_BITS-1:0] sample;

   assign sample = signed'(req_tdata[SAMPLE_BITS-1:0]);

   tapr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tapr_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .sample       (sample),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_kind     (rsp_tuser),
      .rsp_duration (duration)
   );

   // zero fill to whole bytes
   assign rsp_tdata = {{(48 - DUR_BITS){1'b0}}, duration};

   // a pulse-ending sample stalls the input while the duration is computed
   a_busy_after_emit: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.emit) |=> !req_tready)
      else $error("input taken while duration unit busy");

   // output register only fills from a finished computation
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result appeared without a load");

   // only the three pulse kinds leave the block
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_SILENCE || rsp_tuser == KIND_POS
                      || rsp_tuser == KIND_NEG))
      else $error("illegal pulse kind");

   // a load never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

endmodule

// ----- verif/tapr_tb_pkg.sv -----
`timescale 1ns / 1ps

package tapr_tb_pkg;

   import tapr_pkg::*;

   localparam int RUN_BITS = 32;

   typedef enum logic [2:0] {
      PH_START,
      PH_POS_RISE,
      PH_POS_FALL,
      PH_NEG_FALL,
      PH_NEG_RISE
   } wave_phase_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [DUR_BITS-1:0]  duration;
   } pulse_type;

   localparam logic [DUR_BITS-1:0] DUR_ALL_ONES = '1;

   // Half-wave tracker mirror plus the queue of pulses still owed by the block.
   class pulse_scoreboard;
      logic [THR_BITS-1:0]  threshold;
      logic [RATE_BITS-1:0] rate_hz;
      wave_phase_type       phase;
      logic [RUN_BITS-1:0]  run_len;
      pulse_type            pulses_due[$];
      int                   errors;

      function new();
         threshold = THRESHOLD_RESET;
         rate_hz   = RATE_HZ_RESET;
         phase     = PH_START;
         run_len   = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            REG_THRESHOLD: threshold = val[THR_BITS-1:0];
            REG_RATE_HZ:   rate_hz   = val[RATE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // duration = run length * 3.5 MHz / rate, saturating; rate 0 gives all ones
      function void close_pulse(logic [KIND_BITS-1:0] kind);
         logic [63:0] ticks;
         pulse_type   p;
         p.kind = kind;
         if (rate_hz == '0) begin
            p.duration = DUR_ALL_ONES;
         end else begin
            ticks = (64'(run_len) * 64'(TICK_HZ)) / 64'(rate_hz);
            p.duration = (ticks > 64'(DUR_ALL_ONES)) ? DUR_ALL_ONES : ticks[DUR_BITS-1:0];
         end
         pulses_due.push_back(p);
         run_len = '0;
      endfunction

      function void note_sample(logic signed [15:0] s);
         int level;
         int hi;
         int lo;
         level = s;
         hi    = int'(threshold);
         lo    = -hi;
         if (run_len != '1)
            run_len++;
         case (phase)
            PH_POS_RISE: begin
               if (level > hi)
                  phase = PH_POS_FALL;
            end
            PH_POS_FALL: begin
               if (level < 0) begin
                  if (level < lo)
                     phase = PH_NEG_RISE;
                  else
                     phase = PH_NEG_FALL;
                  close_pulse(KIND_POS);
               end
            end
            PH_NEG_FALL: begin
               if (level < lo)
                  phase = PH_NEG_RISE;
            end
            PH_NEG_RISE: begin
               if (level > 0) begin
                  if (level > hi)
                     phase = PH_POS_FALL;
                  else
                     phase = PH_POS_RISE;
                  close_pulse(KIND_NEG);
               end
            end
            default: begin
               if (level > hi) begin
                  phase = PH_POS_FALL;
                  if (run_len > 2)
                     close_pulse(KIND_SILENCE);
               end else if (level < lo) begin
                  phase = PH_NEG_RISE;
                  if (run_len > 2)
                     close_pulse(KIND_SILENCE);
               end
            end
         endcase
      endfunction

      function void check_pulse(logic [KIND_BITS-1:0] kind, logic [DUR_BITS-1:0] dur);
         pulse_type want;
         if (pulses_due.size() == 0) begin
            $error("unexpected pulse: pulse_kind %0d duration %0d", kind, dur);
            errors++;
            return;
         end
         want = pulses_due.pop_front();
         if (kind !== want.kind) begin
            $error("pulse_kind mismatch: expected %0d, actual %0d", want.kind, kind);
            errors++;
         end
         if (dur !== want.duration) begin
            $error("duration mismatch: expected %0d, actual %0d", want.duration, dur);
            errors++;
         end
      endfunction

      function int pending();
         return pulses_due.size();
      endfunction
   endclass

endpackage

// ----- verif/tb_tape_audio_pulse_recovery.sv -----
`timescale 1ns / 1ps

module tb_tape_audio_pulse_recovery;

   import tapr_pkg::*;
   import tapr_tb_pkg::*;

   localparam int SAMPLE_W       = 16;
   // margin over the multiply/divide work of one pulse
   localparam int PULSE_LATENCY  = 120;
   // longest legal quiet stretch is the receiver hold plus one pulse
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RX_HOLD_CYCLES = 1500;
   // zeros in the slow-rate run before the closing swing
   localparam int LONG_RUN       = 40;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [SAMPLE_W-1:0]         req_tdata;   // [15:0] sample
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [47:0]                 rsp_tdata;   // [40:0] duration
   logic [KIND_BITS-1:0]        rsp_tuser;   // [1:0] pulse_kind
   logic                        csr_we;
   logic [CSR_IDX_BITS-1:0]     csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;

   pulse_scoreboard sb = new();

   // stall shaping: quiet flags give stretches with no idling at all
   bit tx_quiet;
   bit rx_quiet;
   // nonzero asks the receiver for a long hold with tready low
   int rx_hold_len;
   int idle_cycles;

   // threshold 2048; tracker is in positive-falling when this starts
   logic signed [SAMPLE_W-1:0] directed_samples [19] = '{
      16'sd3000,    // still positive, no pulse
      -16'sd100,    // positive pulse, lands in negative-falling
      16'sd100,     // ignored while falling negative
      -16'sd2049,   // just past -threshold
      16'sd0,       // zero does not end a negative half-wave
      16'sd50,      // negative pulse, below threshold -> positive-rising
      -16'sd5000,   // missing peak: no change, no pulse
      16'sd2048,    // exactly threshold is not past it
      16'sd32767,   // peak
      -16'sd32768,  // positive pulse straight to negative-rising
      16'sd32767,   // negative pulse straight to positive-falling
      -16'sd1,      // positive pulse, shallow
      -16'sd32768,
      16'sd1,       // negative pulse, shallow
      16'sd32767,
      -16'sd2049,
      16'sd2049,
      16'sh5555,
      16'shAAAA
   };

   tape_audio_pulse_recovery #(
      .SAMPLE_BITS (16),
      .COUNT_BITS  (32)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // mostly no gap, sometimes a few cycles, rarely a long one
   function automatic int gap_len(bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // one sample of a half-wave; the peak usually clears the hysteresis
   function automatic logic signed [SAMPLE_W-1:0] wave_level(bit neg, bit peak);
      int thr;
      int mag;
      thr = int'(sb.threshold);
      if (peak && $urandom_range(0, 4) != 0)
         mag = $urandom_range(thr + 1, 32768);
      else
         mag = $urandom_range(0, thr);
      if (neg)
         return SAMPLE_W'(-mag);
      return SAMPLE_W'((mag > 32767) ? 32767 : mag);
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      req_tdata  = s;
      req_tvalid = 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_sample(s);
      @(negedge clock);
      gap = gap_len(tx_quiet);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // sender stops until every owed pulse is out, then lets the block settle
   task automatic drain_pulses();
      req_tvalid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (PULSE_LATENCY) @(negedge clock);
   endtask

   task automatic set_config(input int thr, input int rate);
      drain_pulses();
      csr_we    = 1'b1;
      csr_index = REG_THRESHOLD;
      csr_wdata = CSR_DATA_BITS'(thr);
      @(negedge clock);
      csr_index = REG_RATE_HZ;
      csr_wdata = CSR_DATA_BITS'(rate);
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(REG_THRESHOLD, CSR_DATA_BITS'(thr));
      sb.write_reg(REG_RATE_HZ, CSR_DATA_BITS'(rate));
   endtask

   // alternating half-waves of random length and amplitude, with some
   // full-range noise mixed in to break the pattern
   task automatic send_waves(input int n_items);
      int sent;
      int len;
      int peak_at;
      bit neg;
      logic signed [SAMPLE_W-1:0] s;
      sent = 0;
      neg  = $urandom_range(0, 1);
      while (sent < n_items) begin
         if ($urandom_range(0, 19) == 0)
            tx_quiet = ~tx_quiet;
         if ($urandom_range(0, 19) == 0)
            rx_quiet = ~rx_quiet;
         if ($urandom_range(0, 9) == 0) begin
            s = SAMPLE_W'($urandom());
            send_sample(s);
            sent++;
         end else begin
            len     = $urandom_range(1, 6);
            peak_at = $urandom_range(0, len - 1);
            for (int k = 0; k < len && sent < n_items; k++) begin
               send_sample(wave_level(neg, k == peak_at));
               sent++;
            end
            neg = ~neg;
         end
      end
   endtask

   // result side: random stalls, plus the long hold the sender can request
   initial begin
      int stall;
      int hold;
      rsp_tready = 1'b0;
      stall      = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_len != 0) begin
            hold        = rx_hold_len;
            rx_hold_len = 0;
            rsp_tready  = 1'b0;
            repeat (hold - 1) @(negedge clock);
         end else if (stall != 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            rsp_tready = 1'b1;
            stall      = gap_len(rx_quiet);
         end
      end
   end

   // pulse checking and watchdog on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_pulse(rsp_tuser, rsp_tdata[DUR_BITS-1:0]);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_index   = REG_THRESHOLD;
      csr_wdata   = '0;
      tx_quiet    = 1'b1;
      rx_quiet    = 1'b0;
      rx_hold_len = 0;
      idle_cycles = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Start phase is only seen once per run, so pick one of its two
      // outcomes: an early first peak (no silence pulse) or a silence
      // pulse of exactly three items (both threshold edges not crossed).
      if ($urandom_range(0, 3) == 0) begin
         send_sample(16'sd0);
         send_sample(16'sd2049);
      end else begin
         send_sample(16'sd2048);
         send_sample(-16'sd2048);
         send_sample(16'sd2049);
      end
      foreach (directed_samples[i])
         send_sample(directed_samples[i]);
      tx_quiet = 1'b0;

      // Zero hysteresis, fastest legal rate.
      set_config(0, 192000);
      send_waves(200);
      // Full-scale hysteresis: only -32768 gets past it; slowest legal rate.
      set_config(32767, 8000);
      send_waves(150);
      // Rate of zero: every duration is all ones.
      set_config(1, 0);
      send_waves(200);
      // Widest rate register value. The receiver sits out a long stretch
      // while samples keep coming, so the output register fills and the
      // block has to push back on the input.
      set_config(2048, 262143);
      rx_hold_len = RX_HOLD_CYCLES;
      send_waves(200);
      set_config($urandom_range(0, 32767), $urandom_range(8000, 192000));
      send_waves(250);
      set_config($urandom_range(0, 4096), 44100);
      send_waves(200);

      // Rate 1 Hz and a run of zeros, which never end a half-wave, then a
      // full swing to close it: a very large duration.
      set_config(2048, 1);
      tx_quiet = 1'b1;
      repeat (LONG_RUN) send_sample(16'sd0);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(16'sd32767);

      drain_pulses();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/tapr_pkg.sv
rtl/core/tapr_ctrl.sv
rtl/core/tapr_dp.sv
rtl/core/tape_audio_pulse_recovery.sv
verif/tapr_tb_pkg.sv
verif/tb_tape_audio_pulse_recovery.sv
